/* rtl/sit_pkg.sv */
// Shared types and result codes for the segment intersection test.
// No dependencies; compile first.
package sit_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned DIFF_W  = COORD_W + 1;
    localparam int unsigned PROD_W  = 2 * DIFF_W;
    localparam int unsigned CROSS_W = PROD_W + 1;
    localparam int unsigned TOL_W   = 16;
    localparam int unsigned HOW_W   = 2;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;
    typedef logic [TOL_W-1:0]          t_tol;
    typedef logic [HOW_W-1:0]          t_how;

    localparam t_how HOW_NONE      = 2'd0;
    localparam t_how HOW_SHARED    = 2'd1;
    localparam t_how HOW_CROSS     = 2'd2;
    localparam t_how HOW_COLLINEAR = 2'd3;

endpackage

/* rtl/sit_if.sv */
// Handshake channels of the segment intersection test: segment pair in,
// verdict out, tolerance write. Depends on sit_pkg.
interface sit_seg_if;
    logic           valid;
    logic           ready;
    sit_pkg::t_coord first_start_x;
    sit_pkg::t_coord first_start_y;
    sit_pkg::t_coord first_end_x;
    sit_pkg::t_coord first_end_y;
    sit_pkg::t_coord second_start_x;
    sit_pkg::t_coord second_start_y;
    sit_pkg::t_coord second_end_x;
    sit_pkg::t_coord second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

interface sit_res_if;
    logic          valid;
    logic          ready;
    logic          meets;
    sit_pkg::t_how how_found;

    modport source (output valid, meets, how_found, input ready);
    modport sink   (input valid, meets, how_found, output ready);
endinterface

interface sit_cfg_if;
    logic          valid;
    logic          ready;
    sit_pkg::t_tol tolerance;

    modport source (output valid, tolerance, input ready);
    modport sink   (input valid, tolerance, output ready);
endinterface

/* rtl/segment_intersection_test.sv */
// Segment intersection test: four-stage pipeline deciding whether two
// segments touch or cross. Depends on sit_pkg and the channels in sit_if.
//
//   channel  dir  beat contents
//   i_seg    in   eight Q16.16 endpoint coordinates of two segments
//   o_res    out  meets, how_found
//   i_cfg    in   tolerance (always ready)
//
// A beat accepted into stage 1 moves through stages 2 and 3 to stage 4, which
// drives o_res; one beat is accepted every cycle while o_res is not stalled. Stages:
// coordinate differences, 33x33 products and bound checks, cross-product
// subtract, verdict.
// Each stage holds its beat until the next one frees up, so bubbles are
// squeezed out while the output stalls. Reset empties the pipeline and
// sets tolerance to 1.
module segment_intersection_test (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sit_seg_if.sink           i_seg,
    sit_res_if.source         o_res,
    sit_cfg_if.sink           i_cfg
);

    localparam int unsigned NPAIR = 4;
    localparam int unsigned CMP_W = sit_pkg::DIFF_W + 1;

    typedef logic signed [CMP_W-1:0] t_cmp;

    sit_pkg::t_tol r_tol;

    // stage 1: differences
    logic          r1_v;
    sit_pkg::t_diff r1_d1x, r1_d1y, r1_d2x, r1_d2y;
    sit_pkg::t_diff r1_ux [NPAIR];
    sit_pkg::t_diff r1_uy [NPAIR];
    sit_pkg::t_diff n1_d1x, n1_d1y, n1_d2x, n1_d2y;
    sit_pkg::t_diff n1_ux [NPAIR];
    sit_pkg::t_diff n1_uy [NPAIR];

    // stage 2: products and bound flags
    logic          r2_v;
    sit_pkg::t_prod r2_ma [NPAIR];
    sit_pkg::t_prod r2_mb [NPAIR];
    logic          r2_close;
    logic [NPAIR-1:0] r2_box;
    sit_pkg::t_prod n2_ma [NPAIR];
    sit_pkg::t_prod n2_mb [NPAIR];
    logic          n2_close;
    logic [NPAIR-1:0] n2_box;

    // stage 3: cross products
    logic          r3_v;
    sit_pkg::t_cross r3_o [NPAIR];
    logic          r3_close;
    logic [NPAIR-1:0] r3_box;
    sit_pkg::t_cross n3_o [NPAIR];

    // stage 4: verdict
    logic          r4_v;
    sit_pkg::t_how r4_how;
    sit_pkg::t_how n4_how;

    logic adv1, adv2, adv3, adv4;

    function automatic sit_pkg::t_diff sub33(sit_pkg::t_coord a, sit_pkg::t_coord b);
        return sit_pkg::t_diff'(a) - sit_pkg::t_diff'(b);
    endfunction

    // inside the box on one axis, given offsets from both corners
    function automatic logic axis_in(sit_pkg::t_diff va, sit_pkg::t_diff vb,
                                     t_cmp tp, t_cmp tn);
        t_cmp a;
        t_cmp b;
        a = t_cmp'(va);
        b = t_cmp'(vb);
        return (a >= tn || b >= tn) && (a <= tp || b <= tp);
    endfunction

    function automatic logic axis_close(sit_pkg::t_diff v, t_cmp tp, t_cmp tn);
        t_cmp a;
        a = t_cmp'(v);
        return (a < tp) && (a > tn);
    endfunction

    assign adv4 = !r4_v || o_res.ready;
    assign adv3 = !r3_v || adv4;
    assign adv2 = !r2_v || adv3;
    assign adv1 = !r1_v || adv2;

    assign i_seg.ready     = adv1;
    assign i_cfg.ready     = 1'b1;
    assign o_res.valid     = r4_v;
    assign o_res.how_found = r4_how;
    assign o_res.meets     = (r4_how != sit_pkg::HOW_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= sit_pkg::TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.tolerance;
        end
    end

    // u[0] = b1-a1, u[1] = b2-a1, u[2] = b1-a2, u[3] = b2-a2
    always_comb begin
        n1_d1x   = sub33(i_seg.first_end_x, i_seg.first_start_x);
        n1_d1y   = sub33(i_seg.first_end_y, i_seg.first_start_y);
        n1_d2x   = sub33(i_seg.second_end_x, i_seg.second_start_x);
        n1_d2y   = sub33(i_seg.second_end_y, i_seg.second_start_y);
        n1_ux[0] = sub33(i_seg.second_start_x, i_seg.first_start_x);
        n1_uy[0] = sub33(i_seg.second_start_y, i_seg.first_start_y);
        n1_ux[1] = sub33(i_seg.second_end_x, i_seg.first_start_x);
        n1_uy[1] = sub33(i_seg.second_end_y, i_seg.first_start_y);
        n1_ux[2] = sub33(i_seg.second_start_x, i_seg.first_end_x);
        n1_uy[2] = sub33(i_seg.second_start_y, i_seg.first_end_y);
        n1_ux[3] = sub33(i_seg.second_end_x, i_seg.first_end_x);
        n1_uy[3] = sub33(i_seg.second_end_y, i_seg.first_end_y);
    end

    // The second segment's orientations are taken with a1-b1 = -u[0] and
    // a2-b1 = -u[2]; both flip sign together, so the crossing test holds.
    always_comb begin
        t_cmp tp;
        t_cmp tn;
        tp = t_cmp'({1'b0, r_tol});
        tn = -tp;

        n2_ma[0] = r1_d1x * r1_uy[0];
        n2_mb[0] = r1_d1y * r1_ux[0];
        n2_ma[1] = r1_d1x * r1_uy[1];
        n2_mb[1] = r1_d1y * r1_ux[1];
        n2_ma[2] = r1_d2x * r1_uy[0];
        n2_mb[2] = r1_d2y * r1_ux[0];
        n2_ma[3] = r1_d2x * r1_uy[2];
        n2_mb[3] = r1_d2y * r1_ux[2];

        n2_close = 1'b0;
        for (int k = 0; k < NPAIR; k++) begin
            n2_close = n2_close || (axis_close(r1_ux[k], tp, tn)
                                    && axis_close(r1_uy[k], tp, tn));
        end

        n2_box[0] = axis_in(r1_ux[0], r1_ux[2], tp, tn)
                    && axis_in(r1_uy[0], r1_uy[2], tp, tn);
        n2_box[1] = axis_in(r1_ux[1], r1_ux[3], tp, tn)
                    && axis_in(r1_uy[1], r1_uy[3], tp, tn);
        n2_box[2] = axis_in(r1_ux[0], r1_ux[1], tp, tn)
                    && axis_in(r1_uy[0], r1_uy[1], tp, tn);
        n2_box[3] = axis_in(r1_ux[2], r1_ux[3], tp, tn)
                    && axis_in(r1_uy[2], r1_uy[3], tp, tn);
    end

    always_comb begin
        for (int k = 0; k < NPAIR; k++) begin
            n3_o[k] = sit_pkg::t_cross'(r2_ma[k]) - sit_pkg::t_cross'(r2_mb[k]);
        end
    end

    always_comb begin
        sit_pkg::t_cross thr;
        logic [NPAIR-1:0] neg;
        logic [NPAIR-1:0] nz;
        logic [NPAIR-1:0] near;
        logic crossing;
        logic coll;
        thr = sit_pkg::t_cross'({1'b0, r_tol, 16'h0000});
        for (int k = 0; k < NPAIR; k++) begin
            neg[k]  = r3_o[k][sit_pkg::CROSS_W-1];
            nz[k]   = |r3_o[k];
            near[k] = (r3_o[k] < thr) && (r3_o[k] > -thr);
        end
        crossing = nz[0] && nz[1] && (neg[0] != neg[1])
                   && nz[2] && nz[3] && (neg[2] != neg[3]);
        coll     = |(near & r3_box);
        if (r3_close) begin
            n4_how = sit_pkg::HOW_SHARED;
        end else if (crossing) begin
            n4_how = sit_pkg::HOW_CROSS;
        end else if (coll) begin
            n4_how = sit_pkg::HOW_COLLINEAR;
        end else begin
            n4_how = sit_pkg::HOW_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (adv1) r1_v <= i_seg.valid;
            if (adv2) r2_v <= r1_v;
            if (adv3) r3_v <= r2_v;
            if (adv4) r4_v <= r3_v;
        end
    end

    // payload: advance with the stage, no reset
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_d1x <= n1_d1x;
            r1_d1y <= n1_d1y;
            r1_d2x <= n1_d2x;
            r1_d2y <= n1_d2y;
            r1_ux  <= n1_ux;
            r1_uy  <= n1_uy;
        end
        if (adv2) begin
            r2_ma    <= n2_ma;
            r2_mb    <= n2_mb;
            r2_close <= n2_close;
            r2_box   <= n2_box;
        end
        if (adv3) begin
            r3_o     <= n3_o;
            r3_close <= r2_close;
            r3_box   <= r2_box;
        end
        if (adv4) begin
            r4_how <= n4_how;
        end
    end

endmodule
